>>> rtl/ctbc_pkg.sv
package ctbc_pkg;

    localparam int unsigned ClockWidth = 32;
    localparam int unsigned RateWidth  = 24;
    localparam int unsigned SumWidth   = 5;

    localparam logic [ClockWidth-1:0] ClockHzReset  = 32'd100000;
    localparam logic [RateWidth-1:0]  FastBitrate   = 24'd1000000;
    localparam logic [SumWidth-1:0]   FastSumStart  = 5'd9;
    localparam logic [SumWidth-1:0]   SlowSumStart  = 5'd16;
    localparam logic [SumWidth-1:0]   SumFloor      = 5'd2;
    localparam logic [ClockWidth-1:0] MaxPrescaler  = 32'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_RATE,
        ST_WAIT_RATE,
        ST_START_SUM,
        ST_WAIT_SUM,
        ST_FINISH
    } ctbc_state_t;

    typedef struct packed {
        logic load;
        logic start_rate;
        logic capture_rate;
        logic start_sum;
        logic step_sum;
        logic capture_presc;
        logic emit;
    } ctbc_cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic div_done;
        logic rem_zero;
        logic sum_low;
        logic out_free;
    } ctbc_status_t;

    typedef struct packed {
        logic [3:0] seg1_code;
        logic [2:0] seg2_code;
        logic [9:0] sample_point;
    } ctbc_timing_t;

    // Segment split and sample point for each segment sum that a search can end on.
    function automatic ctbc_timing_t timing_of(input logic [SumWidth-1:0] sum);
        ctbc_timing_t t;
        case (sum)
            5'd2:    t = '{seg1_code: 4'd0,  seg2_code: 3'd0, sample_point: 10'd666};
            5'd3:    t = '{seg1_code: 4'd1,  seg2_code: 3'd0, sample_point: 10'd750};
            5'd4:    t = '{seg1_code: 4'd2,  seg2_code: 3'd0, sample_point: 10'd800};
            5'd5:    t = '{seg1_code: 4'd3,  seg2_code: 3'd0, sample_point: 10'd833};
            5'd6:    t = '{seg1_code: 4'd4,  seg2_code: 3'd0, sample_point: 10'd857};
            5'd7:    t = '{seg1_code: 4'd5,  seg2_code: 3'd0, sample_point: 10'd875};
            5'd8:    t = '{seg1_code: 4'd6,  seg2_code: 3'd0, sample_point: 10'd888};
            5'd9:    t = '{seg1_code: 4'd7,  seg2_code: 3'd0, sample_point: 10'd900};
            5'd10:   t = '{seg1_code: 4'd7,  seg2_code: 3'd1, sample_point: 10'd818};
            5'd11:   t = '{seg1_code: 4'd8,  seg2_code: 3'd1, sample_point: 10'd833};
            5'd12:   t = '{seg1_code: 4'd9,  seg2_code: 3'd1, sample_point: 10'd846};
            5'd13:   t = '{seg1_code: 4'd10, seg2_code: 3'd1, sample_point: 10'd857};
            5'd14:   t = '{seg1_code: 4'd11, seg2_code: 3'd1, sample_point: 10'd866};
            5'd15:   t = '{seg1_code: 4'd12, seg2_code: 3'd1, sample_point: 10'd875};
            5'd16:   t = '{seg1_code: 4'd13, seg2_code: 3'd1, sample_point: 10'd882};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/ctbc_divider.sv
module ctbc_divider
    import ctbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ClockWidth-1:0] dividend,
    input  logic [RateWidth-1:0]  divisor,
    output logic                  done,
    output logic [ClockWidth-1:0] quotient,
    output logic [RateWidth-1:0]  remainder
);

    localparam int unsigned CntWidth = $clog2(ClockWidth);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CntWidth-1:0]   cnt_reg, cnt_next;
    logic [ClockWidth-1:0] quot_reg, quot_next;
    logic [RateWidth-1:0]  rem_reg, rem_next;
    logic [RateWidth-1:0]  divisor_reg, divisor_next;
    logic [RateWidth:0]    partial;
    logic [RateWidth+1:0]  diff;

    // One quotient bit per cycle, restoring form.
    assign partial = {rem_reg, quot_reg[ClockWidth-1]};
    assign diff    = {1'b0, partial} - {2'b00, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = CntWidth'(ClockWidth - 1);
            quot_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[ClockWidth-2:0], ~diff[RateWidth+1]};
            rem_next  = diff[RateWidth+1] ? partial[RateWidth-1:0] : diff[RateWidth-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/ctbc_datapath.sv
module ctbc_datapath
    import ctbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [ClockWidth-1:0] cfg_wdata,
    input  logic [RateWidth-1:0]  s_target_bitrate,
    input  ctbc_cmd_t             cmd,
    output ctbc_status_t          status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_timing_valid,
    output logic [9:0]            m_prescaler_code,
    output logic                  m_jump_width_code,
    output logic [3:0]            m_segment_one_code,
    output logic [2:0]            m_segment_two_code,
    output logic [9:0]            m_sample_point
);

    logic [ClockWidth-1:0] clock_hz_reg;
    logic [RateWidth-1:0]  rate_reg;
    logic [SumWidth-1:0]   sum_reg, sum_next;
    logic [ClockWidth-1:0] product_reg;
    logic [RateWidth-1:0]  rate_rem_reg;
    logic [ClockWidth-1:0] presc_reg;
    logic                  ok_reg, ok_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  timing_valid_reg;
    logic [9:0]            prescaler_code_reg;
    logic [3:0]            segment_one_code_reg;
    logic [2:0]            segment_two_code_reg;
    logic [9:0]            sample_point_reg;

    logic                  div_start;
    logic [ClockWidth-1:0] div_dividend;
    logic [RateWidth-1:0]  div_divisor;
    logic                  div_done;
    logic [ClockWidth-1:0] div_quot;
    logic [RateWidth-1:0]  div_rem;
    ctbc_timing_t          timing;

    assign div_start    = cmd.start_rate | cmd.start_sum;
    assign div_dividend = cmd.start_rate ? clock_hz_reg : product_reg;
    assign div_divisor  = cmd.start_rate ? rate_reg
                                         : RateWidth'(sum_reg) + RateWidth'(1);

    ctbc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= ClockHzReset;
        end else if (cfg_we) begin
            clock_hz_reg <= cfg_wdata;
        end
    end

    always_comb begin
        sum_next = sum_reg;
        if (cmd.load) begin
            sum_next = (s_target_bitrate >= FastBitrate) ? FastSumStart : SlowSumStart;
        end else if (cmd.step_sum) begin
            sum_next = sum_reg - 1'b1;
        end
    end

    // The exact-bitrate check reduces to the first remainder staying below the product.
    always_comb begin
        ok_next = ok_reg;
        if (cmd.load) begin
            ok_next = 1'b0;
        end else if (cmd.capture_presc) begin
            ok_next = (div_quot != '0) && (div_quot <= MaxPrescaler) &&
                      (ClockWidth'(rate_rem_reg) < product_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rate_reg <= s_target_bitrate;
        end
        if (cmd.capture_rate) begin
            product_reg  <= div_quot;
            rate_rem_reg <= div_rem;
        end
        if (cmd.capture_presc) begin
            presc_reg <= div_quot;
        end
        sum_reg <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else begin
            ok_reg <= ok_next;
        end
    end

    assign timing = timing_of(sum_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            timing_valid_reg     <= ok_reg;
            prescaler_code_reg   <= ok_reg ? 10'(presc_reg - 1'b1) : '0;
            segment_one_code_reg <= ok_reg ? timing.seg1_code : '0;
            segment_two_code_reg <= ok_reg ? timing.seg2_code : '0;
            sample_point_reg     <= ok_reg ? timing.sample_point : '0;
        end
    end

    assign status.rate_zero = (rate_reg == '0);
    assign status.div_done  = div_done;
    assign status.rem_zero  = (div_rem == '0);
    assign status.sum_low   = (sum_reg <= SumFloor);
    assign status.out_free  = ~m_valid_reg | m_ready;

    assign m_valid            = m_valid_reg;
    assign m_timing_valid     = timing_valid_reg;
    assign m_prescaler_code   = prescaler_code_reg;
    assign m_jump_width_code  = 1'b0;
    assign m_segment_one_code = segment_one_code_reg;
    assign m_segment_two_code = segment_two_code_reg;
    assign m_sample_point     = sample_point_reg;

endmodule

>>> rtl/ctbc_ctrl.sv
module ctbc_ctrl
    import ctbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctbc_status_t status,
    output ctbc_cmd_t    cmd
);

    ctbc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START_RATE;
                end
            end
            ST_START_RATE: begin
                if (status.rate_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.start_rate = 1'b1;
                    state_next     = ST_WAIT_RATE;
                end
            end
            ST_WAIT_RATE: begin
                if (status.div_done) begin
                    cmd.capture_rate = 1'b1;
                    state_next       = ST_START_SUM;
                end
            end
            ST_START_SUM: begin
                cmd.start_sum = 1'b1;
                state_next    = ST_WAIT_SUM;
            end
            ST_WAIT_SUM: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        cmd.capture_presc = 1'b1;
                        state_next        = ST_FINISH;
                    end else if (status.sum_low) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.step_sum = 1'b1;
                        state_next   = ST_START_SUM;
                    end
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/can_bit_timing_calculator.sv
// A zero bitrate skips the divider; otherwise the divider runs once for the rate and once
// for each of the n segment sums tried (1 to 8 from 1 Mbit/s up, 1 to 15 below).
// A new beat is taken only once the last one has been emitted; the serial divider is shared.
// A finished result may wait in the output register while the next beat is taken.
// Reset is synchronous and active low; clock_hz returns to 100000 and no result is pending.
module can_bit_timing_calculator
    import ctbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [ClockWidth-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RateWidth-1:0]  s_target_bitrate,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_timing_valid,
    output logic [9:0]            m_prescaler_code,
    output logic                  m_jump_width_code,
    output logic [3:0]            m_segment_one_code,
    output logic [2:0]            m_segment_two_code,
    output logic [9:0]            m_sample_point
);

    ctbc_cmd_t    cmd;
    ctbc_status_t status;

    ctbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ctbc_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_target_bitrate   (s_target_bitrate),
        .cmd                (cmd),
        .status             (status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_timing_valid     (m_timing_valid),
        .m_prescaler_code   (m_prescaler_code),
        .m_jump_width_code  (m_jump_width_code),
        .m_segment_one_code (m_segment_one_code),
        .m_segment_two_code (m_segment_two_code),
        .m_sample_point     (m_sample_point)
    );

endmodule

>>> rtl/ctbc_checker.sv
module ctbc_checker
    import ctbc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_we,
    input logic [ClockWidth-1:0] cfg_wdata,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [RateWidth-1:0]  s_target_bitrate,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_timing_valid,
    input logic [9:0]            m_prescaler_code,
    input logic                  m_jump_width_code,
    input logic [3:0]            m_segment_one_code,
    input logic [2:0]            m_segment_two_code,
    input logic [9:0]            m_sample_point
);

    logic [ClockWidth-1:0] cfg_seen;
    logic [RateWidth-1:0]  rate_seen;
    logic                  beat_in;

    assign cfg_seen  = cfg_wdata & {ClockWidth{cfg_we}};
    assign rate_seen = s_target_bitrate & {RateWidth{s_valid}};
    assign beat_in   = s_valid & s_ready;

    // A beat waiting on the result side holds its fields.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_timing_valid) &&
        $stable(m_prescaler_code) && $stable(m_segment_one_code) &&
        $stable(m_segment_two_code) && $stable(m_sample_point))
        else $error("result beat changed while stalled");

    // A failed search reports every field as zero.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_timing_valid |-> m_prescaler_code == '0 &&
        m_segment_one_code == '0 && m_segment_two_code == '0 &&
        m_sample_point == '0 && m_jump_width_code == 1'b0)
        else $error("invalid result carries nonzero fields");

    // A found timing keeps the sample point within limits and the jump width at one quantum.
    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timing_valid |-> m_sample_point <= 10'd900 &&
        m_sample_point >= 10'd666 && m_segment_two_code <= 3'd1 &&
        m_jump_width_code == 1'b0)
        else $error("valid result outside timing limits");

    // No result comes out of reset: m_valid is low once reset has been held.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !(beat_in && rate_seen == '0 && cfg_seen == '1 && m_valid))
        else $error("result present after reset");

endmodule

bind can_bit_timing_calculator ctbc_checker u_ctbc_checker (.*);

>>> bench/can_bit_timing_calculator_tb.sv
localparam int unsigned FAST_RATE  = 1000000;
localparam int unsigned FAST_SUM   = 9;
localparam int unsigned SLOW_SUM   = 16;
localparam int unsigned MIN_SUM    = 2;
localparam int unsigned MAX_PRESC  = 1024;
localparam int unsigned MAX_SEG1   = 16;
localparam int unsigned MAX_SEG2   = 8;
localparam int unsigned MAX_SAMPLE = 900;

typedef struct packed {
    logic       timing_valid;
    logic [9:0] prescaler_code;
    logic       jump_width_code;
    logic [3:0] segment_one_code;
    logic [2:0] segment_two_code;
    logic [9:0] sample_point;
} bit_timing_t;

class timing_scoreboard;
    int unsigned clock_hz;
    bit_timing_t expected_q[$];
    int          errors;

    function new();
        clock_hz = ctbc_pkg::ClockHzReset;
        errors   = 0;
    endfunction

    function bit_timing_t bit_timing(logic [23:0] rate);
        bit_timing_t t;
        int unsigned quanta, sum, presc, seg1, seg2, sample;
        t = '0;
        if (rate == 0) return t;
        quanta = clock_hz / rate;
        sum = (rate >= FAST_RATE) ? FAST_SUM : SLOW_SUM;
        while (quanta % (sum + 1) != 0) begin
            if (sum <= MIN_SUM) return t;
            sum--;
        end
        presc = quanta / (sum + 1);
        if (presc < 1 || presc > MAX_PRESC) return t;
        // Round the first segment to nearest unless that pushes the sample point too late.
        seg1   = (7 * sum + 3) / 8;
        sample = (1000 * (1 + seg1)) / (1 + sum);
        if (sample > MAX_SAMPLE) begin
            seg1   = (7 * sum - 1) / 8;
            sample = (1000 * (1 + seg1)) / (1 + sum);
        end
        seg2 = sum - seg1;
        if (clock_hz / (presc * (1 + sum)) != rate) return t;
        if (seg1 < 1 || seg1 > MAX_SEG1 || seg2 < 1 || seg2 > MAX_SEG2) return t;
        t.timing_valid     = 1'b1;
        t.prescaler_code   = 10'(presc - 1);
        t.jump_width_code  = 1'b0;
        t.segment_one_code = 4'(seg1 - 1);
        t.segment_two_code = 3'(seg2 - 1);
        t.sample_point     = 10'(sample);
        return t;
    endfunction

    function void note_rate(logic [23:0] rate);
        expected_q.push_back(bit_timing(rate));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_timing(bit_timing_t got);
        bit_timing_t want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("timing_valid", 32'(want.timing_valid), 32'(got.timing_valid));
        compare_field("prescaler_code", 32'(want.prescaler_code), 32'(got.prescaler_code));
        compare_field("jump_width_code", 32'(want.jump_width_code),
                      32'(got.jump_width_code));
        compare_field("segment_one_code", 32'(want.segment_one_code),
                      32'(got.segment_one_code));
        compare_field("segment_two_code", 32'(want.segment_two_code),
                      32'(got.segment_two_code));
        compare_field("sample_point", 32'(want.sample_point), 32'(got.sample_point));
    endfunction
endclass

module can_bit_timing_calculator_tb;
    import ctbc_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  cfg_we           = 1'b0;
    logic [ClockWidth-1:0] cfg_wdata        = '0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [RateWidth-1:0]  s_target_bitrate = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic                  m_timing_valid;
    logic [9:0]            m_prescaler_code;
    logic                  m_jump_width_code;
    logic [3:0]            m_segment_one_code;
    logic [2:0]            m_segment_two_code;
    logic [9:0]            m_sample_point;

    timing_scoreboard sb = new();

    int cycles       = 0;
    int results_seen = 0;
    int hold_left    = 0;
    int ready_left   = 0;
    int stall_left   = 0;
    bit hold_done    = 1'b0;

    can_bit_timing_calculator u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_target_bitrate   (s_target_bitrate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_timing_valid     (m_timing_valid),
        .m_prescaler_code   (m_prescaler_code),
        .m_jump_width_code  (m_jump_width_code),
        .m_segment_one_code (m_segment_one_code),
        .m_segment_two_code (m_segment_two_code),
        .m_sample_point     (m_sample_point)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 4);
        if (pick < 97) return $urandom_range(5, 80);
        return $urandom_range(100, 500);
    endfunction

    function automatic logic [23:0] random_rate(int unsigned clock);
        int unsigned pick, presc, quanta;
        logic [23:0] common[10] = '{10000, 20000, 50000, 83333, 100000,
                                    125000, 250000, 500000, 800000, 1000000};
        logic [23:0] corner[6]  = '{0, 1, 24'hFFFFFF, 1000000, 999999, 9090};
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            presc  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 64)
                                                 : $urandom_range(1, 1100);
            quanta = $urandom_range(3, 17);
            return 24'(clock / (presc * quanta));
        end
        if (pick < 70) return common[$urandom_range(0, 9)];
        if (pick < 75) return corner[$urandom_range(0, 5)];
        return 24'($urandom & ((32'h1 << $urandom_range(1, 24)) - 1));
    endfunction

    // The receiver stalls at random, and once holds off long enough for the block to fill up.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_timing(bit_timing_t'{m_timing_valid, m_prescaler_code, m_jump_width_code,
                                          m_segment_one_code, m_segment_two_code,
                                          m_sample_point});
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 40) begin
            hold_done = 1'b1;
            hold_left = 1500;
            m_ready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            ready_left = $urandom_range(0, 30);
            stall_left = idle_cycles();
            m_ready <= 1'b1;
        end
    end

    task automatic send_rate(input logic [23:0] rate);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_target_bitrate <= rate;
        do @(posedge aclk); while (!s_ready);
        sb.note_rate(rate);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_rate(random_rate(sb.clock_hz));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_clock(input logic [ClockWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.clock_hz = value;
    endtask

    initial begin
        logic [23:0] reset_clock_rates[12] = '{0, 1, 24'hFFFFFF, 100000, 200000, 9090, 9091,
                                               1000000, 5000, 5882, 97, 5};
        logic [23:0] fast_clock_rates[5]   = '{1000000, 500000, 125000, 1000, 999999};
        logic [ClockWidth-1:0] mid_clocks[4] = '{16000000, 40000000, 8000000, 24000000};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (reset_clock_rates[i]) send_rate(reset_clock_rates[i]);
        send_random(180);
        settle();

        write_clock(32'hFFFFFFFF);
        send_rate(1);
        send_rate(24'hFFFFFF);
        send_rate(1000000);
        send_random(180);
        settle();

        write_clock(1);
        send_rate(1);
        send_rate(2);
        send_random(150);
        settle();

        write_clock(80000000);
        foreach (fast_clock_rates[i]) send_rate(fast_clock_rates[i]);
        send_random(200);
        settle();

        foreach (mid_clocks[i]) begin
            write_clock(mid_clocks[i]);
            send_random(170);
            settle();
        end

        write_clock($urandom);
        send_random(120);
        settle();

        write_clock(ClockHzReset);
        send_random(40);
        settle();

        repeat (600) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/ctbc_pkg.sv
rtl/ctbc_divider.sv
rtl/ctbc_datapath.sv
rtl/ctbc_ctrl.sv
rtl/can_bit_timing_calculator.sv
rtl/ctbc_checker.sv
bench/can_bit_timing_calculator_tb.sv
